// ----- sv/v3alu_pkg.sv -----
// ----------------------------------------------------------------------------
// v3alu_pkg
// Shared types, operation codes and saturation helper for the vector unit.
// ----------------------------------------------------------------------------
package v3alu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int PROD_W        = 66;
    localparam int SAT_W         = 72;
    localparam int LANES         = 3;
    localparam int FRONT_LAT     = 3;
    localparam int SQRT_LAT      = 32;
    localparam int SQ_W          = 64;

    // operation codes
    localparam logic [3:0] CMD_ADD    = 4'd0;
    localparam logic [3:0] CMD_SUB    = 4'd1;
    localparam logic [3:0] CMD_SCALE  = 4'd2;
    localparam logic [3:0] CMD_DIV    = 4'd3;
    localparam logic [3:0] CMD_MAG    = 4'd4;
    localparam logic [3:0] CMD_NORM   = 4'd5;
    localparam logic [3:0] CMD_SETMAG = 4'd6;
    localparam logic [3:0] CMD_LIMIT  = 4'd7;
    localparam logic [3:0] CMD_DIST   = 4'd8;
    localparam logic [3:0] CMD_CROSS  = 4'd9;
    localparam logic [3:0] CMD_DOT    = 4'd10;

    // fault codes
    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_ZERO = 2'd1;
    localparam logic [1:0] FAULT_SAT  = 2'd2;

    typedef logic signed [WORD_W-1:0] word_t;

    localparam word_t WORD_MAX = 32'sh7fffffff;
    localparam word_t WORD_MIN = 32'sh80000000;

    typedef struct packed {
        word_t val;
        logic  ovf;
    } sat_t;

    // front lane result toward the merge stage
    typedef struct packed {
        word_t                     r;
        logic                      ovf;
        logic                      big;
        logic signed [PROD_W-1:0]  p;
    } front_out_t;

    // control for one back lane
    typedef struct packed {
        logic div_mode;
        logic neg;
    } back_ctl_t;

    // clamp a wide signed value to the 32-bit range
    function automatic sat_t sat_word(input logic signed [SAT_W-1:0] v);
        sat_t res;
        if (v > $signed(SAT_W'(WORD_MAX)))
        begin
            res.val = WORD_MAX;
            res.ovf = 1'b1;
        end
        else if (v < $signed(SAT_W'(WORD_MIN)))
        begin
            res.val = WORD_MIN;
            res.ovf = 1'b1;
        end
        else
        begin
            res.val = v[WORD_W-1:0];
            res.ovf = 1'b0;
        end
        return res;
    endfunction

endpackage

// ----- sv/vector3_fixed_point_alu_top.sv -----
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu_top
// 3D vector arithmetic unit in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle while item_stall is low and returns one result
// per transaction, in order (Q16.16 at the default FRAC_BITS). Most of the depth
// is in the 32-stage square root pipeline and the 32 + FRAC_BITS stage divider in
// each of the three component lanes, each retiring one bit per stage. The whole
// pipeline holds only when the output register is stalled with a result
// waiting behind it; bubbles ahead of a held result keep moving in.
module vector3_fixed_point_alu_top
    import v3alu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [3:0] command,
    input  word_t      ax,
    input  word_t      ay,
    input  word_t      az,
    input  word_t      bx,
    input  word_t      by,
    input  word_t      bz,
    input  word_t      scalar_in,
    output logic       res_valid,
    input  logic       res_stall,
    output word_t      res_x,
    output word_t      res_y,
    output word_t      res_z,
    output word_t      res_scalar,
    output logic [1:0] fault
);

    localparam int QW       = WORD_W + FRAC_BITS;
    localparam int BACK_LAT = QW + 2;
    localparam int TOT      = 1 + FRONT_LAT + 1 + SQRT_LAT + 1 + BACK_LAT;

    typedef logic [LANES-1:0][WORD_W-1:0] vec_t;

    typedef struct packed {
        logic [3:0] cmd;
        word_t      s;
        vec_t       a;
    } fside_t;

    typedef struct packed {
        logic [3:0] cmd;
        word_t      s;
        vec_t       a;
        vec_t       r;
        logic       ovf;
        word_t      dot;
        logic       dot_ovf;
        logic       big;
    } mside_t;

    typedef struct packed {
        logic  use_back;
        logic  zf;
        vec_t  r;
        logic  ovf;
        word_t sc;
        logic  sc_ovf;
    } fin_t;

    // flow control
    logic           out_load;
    logic           adv;
    logic [TOT-1:0] vld_reg;
    logic           res_valid_reg;

    assign out_load   = !(res_valid_reg && res_stall);
    assign adv        = out_load || !vld_reg[TOT-1];
    assign item_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                vld_reg <= {vld_reg[TOT-2:0], item_valid};
            end
            if (out_load)
            begin
                res_valid_reg <= vld_reg[TOT-1];
            end
        end
    end

    // input register
    logic [3:0] cmd_s1_reg;
    vec_t       a_s1_reg;
    vec_t       b_s1_reg;
    word_t      s_s1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd_s1_reg <= command;
            a_s1_reg   <= {az, ay, ax};
            b_s1_reg   <= {bz, by, bx};
            s_s1_reg   <= scalar_in;
        end
    end

    // front lanes
    front_out_t fo [LANES];

    genvar l;
    generate
        for (l = 0; l < LANES; l++)
        begin : g_front
            v3alu_lane_front #(
                .FRAC_BITS (FRAC_BITS)
            ) u_front (
                .clk (clk),
                .adv (adv),
                .cmd (cmd_s1_reg),
                .a   (a_s1_reg[l]),
                .b   (b_s1_reg[l]),
                .s   (s_s1_reg),
                .ca  (a_s1_reg[(l + 1) % LANES]),
                .cb  (b_s1_reg[(l + 2) % LANES]),
                .da  (a_s1_reg[(l + 2) % LANES]),
                .db  (b_s1_reg[(l + 1) % LANES]),
                .res (fo[l])
            );
        end
    endgenerate

    fside_t fside_reg [FRONT_LAT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fside_reg[0].cmd <= cmd_s1_reg;
            fside_reg[0].s   <= s_s1_reg;
            fside_reg[0].a   <= a_s1_reg;
            for (int k = 1; k < FRONT_LAT; k++)
            begin
                fside_reg[k] <= fside_reg[k-1];
            end
        end
    end

    // merge stage: sum of squares and dot product
    logic signed [PROD_W+1:0] psum;
    sat_t                     dsat;
    logic [SQ_W-1:0]          n_m_reg;
    mside_t                   m_reg;

    always_comb
    begin
        psum = (PROD_W+2)'(fo[0].p) + (PROD_W+2)'(fo[1].p) + (PROD_W+2)'(fo[2].p);
        dsat = sat_word(SAT_W'(psum >>> FRAC_BITS));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_m_reg       <= psum[SQ_W-1:0];
            m_reg.cmd     <= fside_reg[FRONT_LAT-1].cmd;
            m_reg.s       <= fside_reg[FRONT_LAT-1].s;
            m_reg.a       <= fside_reg[FRONT_LAT-1].a;
            m_reg.r       <= {fo[2].r, fo[1].r, fo[0].r};
            m_reg.ovf     <= fo[0].ovf | fo[1].ovf | fo[2].ovf;
            m_reg.dot     <= dsat.val;
            m_reg.dot_ovf <= dsat.ovf;
            m_reg.big     <= fo[0].big | fo[1].big | fo[2].big;
        end
    end

    // square root
    logic [SQRT_LAT-1:0] root;
    mside_t              mside_reg [SQRT_LAT];

    v3alu_sqrt u_sqrt (
        .clk  (clk),
        .adv  (adv),
        .n    (n_m_reg),
        .root (root)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mside_reg[0] <= m_reg;
            for (int k = 1; k < SQRT_LAT; k++)
            begin
                mside_reg[k] <= mside_reg[k-1];
            end
        end
    end

    // decide stage: divider operands and results that skip the divider
    mside_t                 ms;
    logic                   mag_gt;
    logic                   use_norm;
    logic                   is_div;
    logic [WORD_W-1:0]      s_abs;
    logic [WORD_W-1:0]      a_abs [LANES];
    sat_t                   msat;
    fin_t                   fin_next;

    logic [QW-1:0]          num_e_reg [LANES];
    back_ctl_t              ctl_e_reg [LANES];
    logic [WORD_W-1:0]      den_e_reg;
    word_t                  fac_e_reg;
    fin_t                   fin_e_reg;

    always_comb
    begin
        ms       = mside_reg[SQRT_LAT-1];
        mag_gt   = $signed({2'b00, root}) > $signed({{2{ms.s[WORD_W-1]}}, ms.s});
        is_div   = ms.cmd == CMD_DIV;
        use_norm = (ms.cmd == CMD_NORM) || (ms.cmd == CMD_SETMAG)
                   || ((ms.cmd == CMD_LIMIT) && mag_gt);
        s_abs    = ms.s[WORD_W-1] ? WORD_W'(-ms.s) : ms.s;
        for (int k = 0; k < LANES; k++)
        begin
            a_abs[k] = ms.a[k][WORD_W-1] ? WORD_W'(-$signed(ms.a[k])) : ms.a[k];
        end
        msat.val = root[WORD_W-1] ? WORD_MAX : root;
        msat.ovf = root[WORD_W-1];

        fin_next.use_back = is_div || use_norm;
        fin_next.zf       = (is_div && (ms.s == '0)) || (use_norm && (root == '0));
        fin_next.r        = '0;
        fin_next.ovf      = 1'b0;
        fin_next.sc       = '0;
        fin_next.sc_ovf   = 1'b0;
        unique case (ms.cmd)
            CMD_ADD, CMD_SUB, CMD_SCALE, CMD_CROSS:
            begin
                fin_next.r   = ms.r;
                fin_next.ovf = ms.ovf;
            end
            CMD_LIMIT:
            begin
                fin_next.r = ms.a;
            end
            CMD_MAG:
            begin
                fin_next.sc     = msat.val;
                fin_next.sc_ovf = msat.ovf;
            end
            CMD_DIST:
            begin
                fin_next.sc     = ms.big ? WORD_MAX : msat.val;
                fin_next.sc_ovf = ms.big | msat.ovf;
            end
            CMD_DOT:
            begin
                fin_next.sc     = ms.dot;
                fin_next.sc_ovf = ms.dot_ovf;
            end
            default:
            begin
                fin_next.r = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                num_e_reg[k]          <= QW'(a_abs[k]) << FRAC_BITS;
                ctl_e_reg[k].div_mode <= is_div;
                ctl_e_reg[k].neg      <= ms.a[k][WORD_W-1] ^ (is_div & ms.s[WORD_W-1]);
            end
            den_e_reg <= is_div ? s_abs : root;
            fac_e_reg <= (ms.cmd == CMD_NORM) ? word_t'(WORD_W'(1) << FRAC_BITS) : ms.s;
            fin_e_reg <= fin_next;
        end
    end

    // back lanes
    word_t br   [LANES];
    logic  bovf [LANES];

    generate
        for (l = 0; l < LANES; l++)
        begin : g_back
            v3alu_lane_back #(
                .FRAC_BITS (FRAC_BITS)
            ) u_back (
                .clk    (clk),
                .adv    (adv),
                .num    (num_e_reg[l]),
                .den    (den_e_reg),
                .ctl    (ctl_e_reg[l]),
                .factor (fac_e_reg),
                .r      (br[l]),
                .ovf    (bovf[l])
            );
        end
    endgenerate

    fin_t fin_reg [BACK_LAT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fin_reg[0] <= fin_e_reg;
            for (int k = 1; k < BACK_LAT; k++)
            begin
                fin_reg[k] <= fin_reg[k-1];
            end
        end
    end

    // output register
    fin_t       fl;
    word_t      rx_next, ry_next, rz_next;
    logic       vovf;
    logic [1:0] fault_next;

    word_t      res_x_reg, res_y_reg, res_z_reg, res_scalar_reg;
    logic [1:0] fault_reg;

    always_comb
    begin
        fl      = fin_reg[BACK_LAT-1];
        rx_next = fl.use_back ? br[0] : fl.r[0];
        ry_next = fl.use_back ? br[1] : fl.r[1];
        rz_next = fl.use_back ? br[2] : fl.r[2];
        vovf    = fl.use_back ? (bovf[0] | bovf[1] | bovf[2]) : fl.ovf;
        priority if (fl.zf)
        begin
            fault_next = FAULT_ZERO;
        end
        else if (vovf || fl.sc_ovf)
        begin
            fault_next = FAULT_SAT;
        end
        else
        begin
            fault_next = FAULT_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_x_reg      <= fl.zf ? '0 : rx_next;
            res_y_reg      <= fl.zf ? '0 : ry_next;
            res_z_reg      <= fl.zf ? '0 : rz_next;
            res_scalar_reg <= fl.zf ? '0 : fl.sc;
            fault_reg      <= fault_next;
        end
    end

    assign res_valid  = res_valid_reg;
    assign res_x      = res_x_reg;
    assign res_y      = res_y_reg;
    assign res_z      = res_z_reg;
    assign res_scalar = res_scalar_reg;
    assign fault      = fault_reg;

endmodule

// ----- sv/v3alu_lane_front.sv -----
// ----------------------------------------------------------------------------
// v3alu_lane_front
// One component lane: add/sub, operand select, two multipliers, scale/cross.
// ----------------------------------------------------------------------------
module v3alu_lane_front
    import v3alu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic       clk,
    input  logic       adv,
    input  logic [3:0] cmd,
    input  word_t      a,
    input  word_t      b,
    input  word_t      s,
    input  word_t      ca,
    input  word_t      cb,
    input  word_t      da,
    input  word_t      db,
    output front_out_t res
);

    localparam logic signed [WORD_W:0] DMAX = (WORD_W+1)'(WORD_MAX);

    logic signed [WORD_W:0]   sum_w;
    logic signed [WORD_W:0]   dif_w;
    sat_t                     addsub;
    logic signed [WORD_W:0]   op1a, op1b, op2a, op2b;

    logic [3:0]               cmd_a_reg;
    word_t                    r_a_reg;
    logic                     ovf_a_reg;
    logic                     big_a_reg;
    logic signed [WORD_W:0]   op1a_reg, op1b_reg, op2a_reg, op2b_reg;

    logic [3:0]               cmd_b_reg;
    word_t                    r_b_reg;
    logic                     ovf_b_reg;
    logic                     big_b_reg;
    logic signed [PROD_W-1:0] p1_reg, p2_reg;

    logic signed [PROD_W:0]   cdiff;
    sat_t                     scl, crs;
    front_out_t               res_next;
    front_out_t               res_reg;

    // add, subtract and operand selection
    always_comb
    begin
        sum_w  = (WORD_W+1)'(a) + (WORD_W+1)'(b);
        dif_w  = (WORD_W+1)'(a) - (WORD_W+1)'(b);
        addsub = (cmd == CMD_ADD) ? sat_word(SAT_W'(sum_w)) : sat_word(SAT_W'(dif_w));
        op2a   = '0;
        op2b   = '0;
        unique case (cmd)
            CMD_SCALE:
            begin
                op1a = (WORD_W+1)'(a);
                op1b = (WORD_W+1)'(s);
            end
            CMD_DOT:
            begin
                op1a = (WORD_W+1)'(a);
                op1b = (WORD_W+1)'(b);
            end
            CMD_CROSS:
            begin
                op1a = (WORD_W+1)'(ca);
                op1b = (WORD_W+1)'(cb);
                op2a = (WORD_W+1)'(da);
                op2b = (WORD_W+1)'(db);
            end
            CMD_DIST:
            begin
                op1a = dif_w;
                op1b = dif_w;
            end
            default:
            begin
                op1a = (WORD_W+1)'(a);
                op1b = (WORD_W+1)'(a);
            end
        endcase
    end

    // stage a: operands
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd_a_reg <= cmd;
            r_a_reg   <= (cmd == CMD_ADD || cmd == CMD_SUB) ? addsub.val : '0;
            ovf_a_reg <= (cmd == CMD_ADD || cmd == CMD_SUB) && addsub.ovf;
            big_a_reg <= (dif_w > DMAX) || (dif_w < -DMAX);
            op1a_reg  <= op1a;
            op1b_reg  <= op1b;
            op2a_reg  <= op2a;
            op2b_reg  <= op2b;
        end
    end

    // stage b: products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd_b_reg <= cmd_a_reg;
            r_b_reg   <= r_a_reg;
            ovf_b_reg <= ovf_a_reg;
            big_b_reg <= big_a_reg;
            p1_reg    <= PROD_W'(op1a_reg) * PROD_W'(op1b_reg);
            p2_reg    <= PROD_W'(op2a_reg) * PROD_W'(op2b_reg);
        end
    end

    // stage c: rescale scale and cross results
    always_comb
    begin
        cdiff        = (PROD_W+1)'(p1_reg) - (PROD_W+1)'(p2_reg);
        scl          = sat_word(SAT_W'(p1_reg >>> FRAC_BITS));
        crs          = sat_word(SAT_W'(cdiff >>> FRAC_BITS));
        res_next.big = big_b_reg;
        res_next.p   = p1_reg;
        unique case (cmd_b_reg)
            CMD_SCALE:
            begin
                res_next.r   = scl.val;
                res_next.ovf = scl.ovf;
            end
            CMD_CROSS:
            begin
                res_next.r   = crs.val;
                res_next.ovf = crs.ovf;
            end
            default:
            begin
                res_next.r   = r_b_reg;
                res_next.ovf = ovf_b_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ----- sv/v3alu_sqrt.sv -----
// ----------------------------------------------------------------------------
// v3alu_sqrt
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module v3alu_sqrt
    import v3alu_pkg::*;
(
    input  logic                clk,
    input  logic                adv,
    input  logic [SQ_W-1:0]     n,
    output logic [SQRT_LAT-1:0] root
);

    localparam int TW = SQ_W + 2;

    logic [SQ_W-1:0]     rem_reg  [SQRT_LAT];
    logic [SQRT_LAT-1:0] root_reg [SQRT_LAT];

    genvar k;
    generate
        for (k = 0; k < SQRT_LAT; k++)
        begin : g_stage
            localparam int BIT = SQRT_LAT - 1 - k;
            logic [SQ_W-1:0]     rin;
            logic [SQRT_LAT-1:0] qin;
            logic [TW-1:0]       trial;
            logic [TW-1:0]       rext;
            logic [TW-1:0]       rdif;
            logic                ge;

            if (k == 0)
            begin : g_first
                assign rin = n;
                assign qin = '0;
            end
            else
            begin : g_next
                assign rin = rem_reg[k-1];
                assign qin = root_reg[k-1];
            end

            // try setting this root bit
            always_comb
            begin
                trial = (TW'(qin) << (BIT + 1)) + (TW'(1) << (2 * BIT));
                rext  = TW'(rin);
                rdif  = rext - trial;
                ge    = rext >= trial;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[k]  <= ge ? rdif[SQ_W-1:0] : rin;
                    root_reg[k] <= ge ? (qin | (SQRT_LAT'(1) << BIT)) : qin;
                end
            end
        end
    endgenerate

    assign root = root_reg[SQRT_LAT-1];

endmodule

// ----- sv/v3alu_lane_back.sv -----
// ----------------------------------------------------------------------------
// v3alu_lane_back
// One component lane: pipelined restoring divider, then the rescale multiply.
// ----------------------------------------------------------------------------
module v3alu_lane_back
    import v3alu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        adv,
    input  logic [WORD_W+FRAC_BITS-1:0] num,
    input  logic [WORD_W-1:0]           den,
    input  back_ctl_t                   ctl,
    input  word_t                       factor,
    output word_t                       r,
    output logic                        ovf
);

    localparam int QW = WORD_W + FRAC_BITS;
    localparam int NW = FRAC_BITS + 2;
    localparam int MW = NW + WORD_W;

    logic [WORD_W-1:0] rem_reg [QW];
    logic [QW-1:0]     nq_reg  [QW];
    logic [WORD_W-1:0] den_reg [QW];
    back_ctl_t         ctl_reg [QW];
    word_t             fac_reg [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++)
        begin : g_stage
            logic [WORD_W-1:0] rin;
            logic [QW-1:0]     nin;
            logic [WORD_W-1:0] din;
            back_ctl_t         cin;
            word_t             fin;
            logic [WORD_W:0]   trial;
            logic [WORD_W:0]   diff;
            logic              ge;

            if (k == 0)
            begin : g_first
                assign rin = '0;
                assign nin = num;
                assign din = den;
                assign cin = ctl;
                assign fin = factor;
            end
            else
            begin : g_next
                assign rin = rem_reg[k-1];
                assign nin = nq_reg[k-1];
                assign din = den_reg[k-1];
                assign cin = ctl_reg[k-1];
                assign fin = fac_reg[k-1];
            end

            // one quotient bit
            always_comb
            begin
                trial = {rin, nin[QW-1]};
                diff  = trial - {1'b0, din};
                ge    = trial >= {1'b0, din};
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[k] <= ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
                    nq_reg[k]  <= {nin[QW-2:0], ge};
                    den_reg[k] <= din;
                    ctl_reg[k] <= cin;
                    fac_reg[k] <= fin;
                end
            end
        end
    endgenerate

    logic signed [QW:0]    qs;
    logic signed [NW-1:0]  nrm;
    sat_t                  dsat;
    logic                  g_mode_reg;
    sat_t                  g_div_reg;
    logic signed [MW-1:0]  g_prod_reg;
    sat_t                  nsat;
    word_t                 r_reg;
    logic                  ovf_reg;

    // signed quotient and its saturated form
    always_comb
    begin
        qs   = ctl_reg[QW-1].neg ? -$signed({1'b0, nq_reg[QW-1]})
                                 : $signed({1'b0, nq_reg[QW-1]});
        nrm  = qs[NW-1:0];
        dsat = sat_word(SAT_W'(qs));
    end

    // multiply stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_mode_reg <= ctl_reg[QW-1].div_mode;
            g_div_reg  <= dsat;
            g_prod_reg <= MW'(nrm) * MW'(fac_reg[QW-1]);
        end
    end

    // rescale and clamp
    assign nsat = sat_word(SAT_W'(g_prod_reg >>> FRAC_BITS));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg   <= g_mode_reg ? g_div_reg.val : nsat.val;
            ovf_reg <= g_mode_reg ? g_div_reg.ovf : nsat.ovf;
        end
    end

    assign r   = r_reg;
    assign ovf = ovf_reg;

endmodule

// ----- sv/v3alu_checker.sv -----
// ----------------------------------------------------------------------------
// v3alu_checker
// Port-level checks on the vector unit, bound to the top level.
// ----------------------------------------------------------------------------
module v3alu_checker
    import v3alu_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       item_stall,
    input logic       res_valid,
    input logic       res_stall,
    input word_t      res_x,
    input word_t      res_y,
    input word_t      res_z,
    input word_t      res_scalar,
    input logic [1:0] fault
);

    // a stalled result transaction stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> res_valid)
        else $error("result valid dropped while stalled");

    // a stalled result payload holds
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> ($stable(res_x) && $stable(res_y)
            && $stable(res_z) && $stable(res_scalar) && $stable(fault)))
        else $error("result payload changed while stalled");

    // input only backs up behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (res_valid && res_stall))
        else $error("input stalled without a held result");

    // a zero-divisor fault clears every field
    a_zero_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && fault == FAULT_ZERO) |-> (res_x == '0 && res_y == '0
            && res_z == '0 && res_scalar == '0))
        else $error("fault one with nonzero result");

endmodule

bind vector3_fixed_point_alu_top v3alu_checker u_checker (.*);

// ----- bench/vector3_fixed_point_alu_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu_checker
// Watches both channels of the vector unit, computes the expected result of
// every accepted transaction and compares it with the returned result.
// ----------------------------------------------------------------------------
module vector3_fixed_point_alu_checker
    import v3alu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic       item_stall,
    input  logic [3:0] command,
    input  word_t      ax,
    input  word_t      ay,
    input  word_t      az,
    input  word_t      bx,
    input  word_t      by,
    input  word_t      bz,
    input  word_t      scalar_in,
    input  logic       res_valid,
    input  logic       res_stall,
    input  word_t      res_x,
    input  word_t      res_y,
    input  word_t      res_z,
    input  word_t      res_scalar,
    input  logic [1:0] fault,
    output int         errors,
    output int         pending
);

    typedef struct packed {
        word_t      x;
        word_t      y;
        word_t      z;
        word_t      s;
        logic [1:0] f;
    } vec_result_t;

    typedef logic signed [127:0] wide_t;

    vec_result_t result_fifo[$];

    assign pending = result_fifo.size();

    // floor shift of a wide signed value
    function automatic wide_t floor_shift(input wide_t v, input int k);
        return v >>> k;
    endfunction

    // clamp to 32 bits, raising the overflow flag
    function automatic word_t clamp_word(input wide_t v, inout logic ovf);
        if (v > wide_t'(64'sd2147483647))
        begin
            ovf = 1'b1;
            return WORD_MAX;
        end
        if (v < -wide_t'(64'sd2147483648))
        begin
            ovf = 1'b1;
            return WORD_MIN;
        end
        return v[31:0];
    endfunction

    // floor integer square root
    function automatic wide_t int_sqrt(input wide_t n);
        logic [127:0] rem, root, bitv;
        rem = n;
        root = 0;
        bitv = 128'd1 << 126;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return wide_t'(root);
    endfunction

    // signed division truncating toward zero
    function automatic wide_t div_trunc(input wide_t num, input wide_t den);
        wide_t q;
        q = (num < 0 ? -num : num) / (den < 0 ? -den : den);
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    // rescale vector a to magnitude s; zero vector gives zero_vec
    function automatic void rescale(input wide_t a[3], input wide_t s, output wide_t r[3],
                                    inout logic ovf, output logic zero_vec);
        wide_t m, n;
        m = int_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
        zero_vec = (m == 0);
        for (int i = 0; i < 3; i++)
        begin
            r[i] = 0;
            if (!zero_vec)
            begin
                n = div_trunc(a[i] <<< FRAC_BITS, m);
                r[i] = clamp_word(floor_shift(n * s, FRAC_BITS), ovf);
            end
        end
    endfunction

    function automatic vec_result_t compute_vector_op(input logic [3:0] cmd,
            input word_t vax, input word_t vay, input word_t vaz, input word_t vbx,
            input word_t vby, input word_t vbz, input word_t vs);
        wide_t a[3], b[3], r[3], d[3], s, sc, m;
        logic ovf, zf, big;
        vec_result_t res;
        a[0] = vax; a[1] = vay; a[2] = vaz;
        b[0] = vbx; b[1] = vby; b[2] = vbz;
        s = vs;
        r[0] = 0; r[1] = 0; r[2] = 0;
        sc = 0;
        ovf = 1'b0;
        zf = 1'b0;
        big = 1'b0;
        case (cmd)
            CMD_ADD:
                for (int i = 0; i < 3; i++) r[i] = clamp_word(a[i] + b[i], ovf);
            CMD_SUB:
                for (int i = 0; i < 3; i++) r[i] = clamp_word(a[i] - b[i], ovf);
            CMD_SCALE:
                for (int i = 0; i < 3; i++)
                    r[i] = clamp_word(floor_shift(a[i] * s, FRAC_BITS), ovf);
            CMD_DIV:
                if (s == 0)
                    zf = 1'b1;
                else
                    for (int i = 0; i < 3; i++)
                        r[i] = clamp_word(div_trunc(a[i] <<< FRAC_BITS, s), ovf);
            CMD_MAG:
                sc = clamp_word(int_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]), ovf);
            CMD_NORM:
                rescale(a, wide_t'(1) <<< FRAC_BITS, r, ovf, zf);
            CMD_SETMAG:
                rescale(a, s, r, ovf, zf);
            CMD_LIMIT:
            begin
                m = int_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
                if (m > s)
                    rescale(a, s, r, ovf, zf);
                else
                    for (int i = 0; i < 3; i++) r[i] = a[i];
            end
            CMD_DIST:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    d[i] = a[i] - b[i];
                    if (d[i] > 2147483647 || d[i] < -2147483647)
                        big = 1'b1;
                end
                if (big)
                begin
                    sc = 2147483647;
                    ovf = 1'b1;
                end
                else
                    sc = clamp_word(int_sqrt(d[0] * d[0] + d[1] * d[1] + d[2] * d[2]), ovf);
            end
            CMD_CROSS:
            begin
                r[0] = clamp_word(floor_shift(a[1] * b[2] - a[2] * b[1], FRAC_BITS), ovf);
                r[1] = clamp_word(floor_shift(a[2] * b[0] - a[0] * b[2], FRAC_BITS), ovf);
                r[2] = clamp_word(floor_shift(a[0] * b[1] - a[1] * b[0], FRAC_BITS), ovf);
            end
            CMD_DOT:
                sc = clamp_word(floor_shift(a[0] * b[0] + a[1] * b[1] + a[2] * b[2],
                                            FRAC_BITS), ovf);
            default:
                ;
        endcase
        if (zf)
        begin
            r[0] = 0; r[1] = 0; r[2] = 0;
            sc = 0;
        end
        res.x = r[0][31:0];
        res.y = r[1][31:0];
        res.z = r[2][31:0];
        res.s = sc[31:0];
        res.f = zf ? FAULT_ZERO : (ovf ? FAULT_SAT : FAULT_NONE);
        return res;
    endfunction

    // predict on input transactions, compare on output transactions
    always @(posedge clk or negedge rst_n)
    begin
        vec_result_t want;
        if (!rst_n)
            errors <= 0;
        else
        begin
            if (item_valid && !item_stall)
                result_fifo.push_back(compute_vector_op(command, ax, ay, az, bx, by, bz,
                                                        scalar_in));
            if (res_valid && !res_stall)
            begin
                if (result_fifo.size() == 0)
                begin
                    $display("%0t: unexpected result x=%h y=%h z=%h s=%h f=%0d",
                             $time, res_x, res_y, res_z, res_scalar, fault);
                    errors <= errors + 1;
                end
                else
                begin
                    want = result_fifo.pop_front();
                    if (want.x !== res_x || want.y !== res_y || want.z !== res_z ||
                        want.s !== res_scalar || want.f !== fault)
                    begin
                        $display("%0t: expected x=%h y=%h z=%h s=%h f=%0d", $time,
                                 want.x, want.y, want.z, want.s, want.f);
                        $display("%0t: actual   x=%h y=%h z=%h s=%h f=%0d", $time,
                                 res_x, res_y, res_z, res_scalar, fault);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- bench/vector3_fixed_point_alu_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu_top_tb
// Drives directed and random transactions into the vector unit with random
// gaps and output stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module vector3_fixed_point_alu_top_tb;
    import v3alu_pkg::*;

    localparam int RANDOM_ITEMS = 550;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 120;

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_stall;
    logic [3:0] command;
    word_t      ax, ay, az, bx, by, bz, scalar_in;
    logic       res_valid;
    logic       res_stall;
    word_t      res_x, res_y, res_z, res_scalar;
    logic [1:0] fault;
    int         errors;
    int         pending;
    int         idle_cycles;
    bit         quiet_stall;

    vector3_fixed_point_alu_top dut (.*);

    vector3_fixed_point_alu_checker checker_i (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver stalls at random, except during the quiet stretch
    always @(posedge clk)
        res_stall <= quiet_stall ? 1'b0 : ($urandom_range(99) < 21);

    // watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("vector3_fixed_point_alu_top: mismatch");
            $finish;
        end
    end

    // random component: mix of extremes, small values and full range
    function automatic word_t pick_word();
        case ($urandom_range(7))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return 0;
            3, 4: return $signed($urandom_range(32'h0003ffff)) - 32'sh00020000;
            default: return $urandom;
        endcase
    endfunction

    // send one transaction, with an optional idle gap ahead of it
    task automatic send_item(input logic [3:0] cmd, input word_t vax, input word_t vay,
                             input word_t vaz, input word_t vbx, input word_t vby,
                             input word_t vbz, input word_t vs, input bit gaps);
        while (gaps && $urandom_range(99) < 21)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        command <= cmd;
        ax <= vax; ay <= vay; az <= vaz;
        bx <= vbx; by <= vby; bz <= vbz;
        scalar_in <= vs;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    initial
    begin
        word_t one;
        one = 32'sh00010000;
        rst_n = 1'b0;
        item_valid = 1'b0;
        command = CMD_ADD;
        {ax, ay, az, bx, by, bz, scalar_in} = '0;
        res_stall = 1'b0;
        quiet_stall = 1'b0;
        idle_cycles = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every operation and the corner cases
        send_item(CMD_ADD, WORD_MAX, WORD_MIN, one, one, WORD_MIN, one, 0, 0);
        send_item(CMD_SUB, WORD_MIN, WORD_MAX, 0, one, WORD_MIN, -one, 0, 0);
        send_item(CMD_SCALE, WORD_MAX, WORD_MIN, one, 1, 0, 0, WORD_MAX, 0);
        send_item(CMD_DIV, one, -one, 3, 0, 0, 0, 0, 0);
        send_item(CMD_DIV, WORD_MAX, WORD_MIN, one, 0, 0, 0, 1, 0);
        send_item(CMD_DIV, -7, 7, one, 0, 0, 0, -3 * one, 0);
        send_item(CMD_MAG, WORD_MAX, WORD_MAX, WORD_MIN, 0, 0, 0, 0, 0);
        send_item(CMD_MAG, 3 * one, 4 * one, 0, 0, 0, 0, 0, 0);
        send_item(CMD_NORM, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(CMD_NORM, 1, 0, 0, 0, 0, 0, 0, 0);
        send_item(CMD_NORM, WORD_MIN, WORD_MAX, 5, 0, 0, 0, 0, 0);
        send_item(CMD_SETMAG, 0, 0, 0, 0, 0, 0, one, 0);
        send_item(CMD_SETMAG, 1, 0, 0, 0, 0, 0, WORD_MAX, 0);
        send_item(CMD_LIMIT, 3 * one, 4 * one, 0, 0, 0, 0, 2 * one, 0);
        send_item(CMD_LIMIT, 3 * one, 4 * one, 0, 0, 0, 0, 9 * one, 0);
        send_item(CMD_LIMIT, one, one, 0, 0, 0, 0, -one, 0);
        send_item(CMD_LIMIT, 0, 0, 0, 0, 0, 0, -one, 0);
        send_item(CMD_DIST, WORD_MAX, 0, 0, WORD_MIN, 0, 0, 0, 0);
        send_item(CMD_DIST, WORD_MAX, WORD_MAX, WORD_MAX, 0, 0, 0, 0, 0);
        send_item(CMD_CROSS, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, 0, 0);
        send_item(CMD_CROSS, one, 0, 0, 0, one, 0, 0, 0);
        send_item(CMD_DOT, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 0, 0);
        send_item(CMD_DOT, -1, 1, 0, 1, 1, 0, 0, 0);
        send_item(4'd11, one, one, one, one, one, one, one, 0);
        send_item(4'd15, -1, -1, -1, -1, -1, -1, -1, 0);

        // hold off until the pipeline has emptied
        item_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);

        // random transactions; a quiet stretch in the middle
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet_stall <= (n >= 200 && n < 300);
            send_item((n % 20 == 19) ? 4'($urandom_range(15)) : 4'($urandom_range(10)),
                      pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
                      pick_word(), pick_word(), !(n >= 200 && n < 300));
        end
        item_valid <= 1'b0;
        quiet_stall <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("vector3_fixed_point_alu_top: match");
        else
            $display("vector3_fixed_point_alu_top: mismatch");
        $finish;
    end

endmodule
